FILE: design/rdft_pkg.sv
// Shared constants, control/status structs and twiddle ROM helpers for row_dft_engine.
// No dependencies; every other design file but rdft_cfg_if imports this package.
package rdft_pkg;

  // Field widths of the sample and bin channels
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned BIN_W     = 38;
  localparam int unsigned BIN_IDX_W = 6;
  localparam int unsigned TERM_W    = 2 * SAMPLE_W + 1;

  // Twiddle generation: pi/2 in Q2.30
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_en;    // write the accepted sample and advance the load counter
    logic row_start;  // first bin of a row: bin counter to zero
    logic bin_start;  // sample and twiddle counters to zero
    logic mac_issue;  // issue one multiply-accumulate step
    logic emit;       // move the finished bin into the output register
  } rdft_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic load_last;  // next sample completes the row
    logic n_last;     // current step is the last sample of the bin
    logic l_last;     // current bin is the last of the row
    logic pipe_busy;  // MAC pipeline still holds steps in flight
    logic out_free;   // output register can take a bin this cycle
  } rdft_stat_t;

  // Q2.30 series sum rounded to Q1.15 and clamped to 0..32767. Elaboration-time only.
  function automatic logic [SAMPLE_W-1:0] q15_round(input longint v);
    longint r;
    if (v < 0) begin
      r = 0;
    end else begin
      r = (v + (64'sd1 <<< 14)) >>> 15;
      if (r > 32767) begin
        r = 32767;
      end
    end
    return SAMPLE_W'(r);
  endfunction

endpackage

FILE: design/rdft_sample_if.sv
// Sample channel: valid/ready handshake carrying one complex Q1.15 sample per item.
// Depends on rdft_pkg.
interface rdft_sample_if;
  import rdft_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_re;
  logic signed [SAMPLE_W-1:0] sample_im;

  modport source (output valid, output sample_re, output sample_im, input ready);
  modport sink   (input valid, input sample_re, input sample_im, output ready);
endinterface

FILE: design/rdft_bin_if.sv
// Bin channel: valid/ready handshake carrying one DFT bin per item.
// Depends on rdft_pkg.
interface rdft_bin_if;
  import rdft_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [BIN_W-1:0] bin_re;
  logic signed [BIN_W-1:0] bin_im;
  logic [BIN_IDX_W-1:0]    bin_index;
  logic                    last_bin;

  modport source (output valid, output bin_re, output bin_im, output bin_index,
                  output last_bin, input ready);
  modport sink   (input valid, input bin_re, input bin_im, input bin_index,
                  input last_bin, output ready);
endinterface

FILE: design/rdft_cfg_if.sv
// Configuration write channel: valid/ready handshake carrying the direction register.
// No dependencies.
interface rdft_cfg_if;
  logic valid;
  logic ready;
  logic direction;

  modport source (output valid, output direction, input ready);
  modport sink   (input valid, input direction, output ready);
endinterface

FILE: design/rdft_ctrl.sv
// Controller FSM for row_dft_engine: sequences row load, per-bin MAC runs and bin output.
// Depends on rdft_pkg (command and status structs).
module rdft_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                sample_valid_i,
  output logic                sample_ready_o,
  input  rdft_pkg::rdft_stat_t stat_i,
  output rdft_pkg::rdft_cmd_t  cmd_o
);
  import rdft_pkg::*;

  typedef enum logic [3:0] {
    ST_LOAD  = 4'b0001,
    ST_MAC   = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_EMIT  = 4'b1000
  } rdft_state_e;

  rdft_state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    sample_ready_o = 1'b0;
    case (state_q)
      ST_LOAD: begin
        sample_ready_o = 1'b1;
        if (sample_valid_i) begin
          cmd_o.load_en = 1'b1;
          if (stat_i.load_last) begin
            cmd_o.row_start = 1'b1;
            cmd_o.bin_start = 1'b1;
            state_d         = ST_MAC;
          end
        end
      end
      ST_MAC: begin
        cmd_o.mac_issue = 1'b1;
        if (stat_i.n_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!stat_i.pipe_busy) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (stat_i.l_last) begin
            state_d = ST_LOAD;
          end else begin
            cmd_o.bin_start = 1'b1;
            state_d         = ST_MAC;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: design/rdft_datapath.sv
// Datapath for row_dft_engine: row store, twiddle ROM, counters, MAC pipeline, output register.
// Depends on rdft_pkg (widths, command/status structs, rounding function).
module rdft_datapath #(
  parameter int unsigned POINTS = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  rdft_pkg::rdft_cmd_t                  cmd_i,
  output rdft_pkg::rdft_stat_t                 stat_o,
  input  logic signed [rdft_pkg::SAMPLE_W-1:0] sample_re_i,
  input  logic signed [rdft_pkg::SAMPLE_W-1:0] sample_im_i,
  input  logic                                 cfg_we_i,
  input  logic                                 cfg_direction_i,
  output logic                                 bin_valid_o,
  input  logic                                 bin_ready_i,
  output logic signed [rdft_pkg::BIN_W-1:0]    bin_re_o,
  output logic signed [rdft_pkg::BIN_W-1:0]    bin_im_o,
  output logic [rdft_pkg::BIN_IDX_W-1:0]       bin_index_o,
  output logic                                 last_bin_o
);
  import rdft_pkg::*;

  localparam int unsigned       IDX_W    = $clog2(POINTS);
  localparam logic [IDX_W:0]    POINTS_W = (IDX_W + 1)'(POINTS);
  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(POINTS - 1);

  // Twiddle ROM, built at elaboration from the quadrant and first-quadrant series
  logic signed [SAMPLE_W-1:0] rom_cos [POINTS];
  logic signed [SAMPLE_W-1:0] rom_sin [POINTS];

  for (genvar g = 0; g < POINTS; g++) begin : g_rom
    localparam longint unsigned QUAD = (64'(g) * 64'd4) / POINTS;
    localparam longint unsigned REM  = (64'(g) * 64'd4) % POINTS;
    localparam longint unsigned ANG  = (HALF_PI_Q30 * REM) / POINTS;
    localparam longint unsigned A2   = (ANG * ANG) >> 30;
    // sine terms a^(2n+1)/(2n+1)!, floor at every step
    localparam longint unsigned TS1  = ((ANG  * A2) >> 30) / 64'd6;
    localparam longint unsigned TS2  = ((TS1  * A2) >> 30) / 64'd20;
    localparam longint unsigned TS3  = ((TS2  * A2) >> 30) / 64'd42;
    localparam longint unsigned TS4  = ((TS3  * A2) >> 30) / 64'd72;
    localparam longint unsigned TS5  = ((TS4  * A2) >> 30) / 64'd110;
    localparam longint unsigned TS6  = ((TS5  * A2) >> 30) / 64'd156;
    localparam longint unsigned TS7  = ((TS6  * A2) >> 30) / 64'd210;
    localparam longint unsigned TS8  = ((TS7  * A2) >> 30) / 64'd272;
    localparam longint unsigned TS9  = ((TS8  * A2) >> 30) / 64'd342;
    localparam longint unsigned TS10 = ((TS9  * A2) >> 30) / 64'd420;
    // cosine terms a^(2n)/(2n)!
    localparam longint unsigned TC0  = 64'd1 << 30;
    localparam longint unsigned TC1  = ((TC0  * A2) >> 30) / 64'd2;
    localparam longint unsigned TC2  = ((TC1  * A2) >> 30) / 64'd12;
    localparam longint unsigned TC3  = ((TC2  * A2) >> 30) / 64'd30;
    localparam longint unsigned TC4  = ((TC3  * A2) >> 30) / 64'd56;
    localparam longint unsigned TC5  = ((TC4  * A2) >> 30) / 64'd90;
    localparam longint unsigned TC6  = ((TC5  * A2) >> 30) / 64'd132;
    localparam longint unsigned TC7  = ((TC6  * A2) >> 30) / 64'd182;
    localparam longint unsigned TC8  = ((TC7  * A2) >> 30) / 64'd240;
    localparam longint unsigned TC9  = ((TC8  * A2) >> 30) / 64'd306;
    localparam longint unsigned TC10 = ((TC9  * A2) >> 30) / 64'd380;
    // alternating sums
    localparam longint SIN_SUM = longint'(ANG) - longint'(TS1) + longint'(TS2)
        - longint'(TS3) + longint'(TS4) - longint'(TS5) + longint'(TS6)
        - longint'(TS7) + longint'(TS8) - longint'(TS9) + longint'(TS10);
    localparam longint COS_SUM = longint'(TC0) - longint'(TC1) + longint'(TC2)
        - longint'(TC3) + longint'(TC4) - longint'(TC5) + longint'(TC6)
        - longint'(TC7) + longint'(TC8) - longint'(TC9) + longint'(TC10);
    localparam logic signed [SAMPLE_W-1:0] C0 = q15_round(COS_SUM);
    localparam logic signed [SAMPLE_W-1:0] S0 = q15_round(SIN_SUM);
    localparam logic signed [SAMPLE_W-1:0] TW_C =
        (QUAD == 0) ? C0 : (QUAD == 1) ? -S0 : (QUAD == 2) ? -C0 : S0;
    localparam logic signed [SAMPLE_W-1:0] TW_S =
        (QUAD == 0) ? S0 : (QUAD == 1) ? C0 : (QUAD == 2) ? -S0 : -C0;
    assign rom_cos[g] = TW_C;
    assign rom_sin[g] = TW_S;
  end

  // Direction register
  logic dir_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= 1'b0;
    end else if (cfg_we_i) begin
      dir_q <= cfg_direction_i;
    end
  end

  // Counters: load position, sample n, bin l, twiddle index k = l*n mod POINTS
  logic [IDX_W-1:0] load_cnt_q, n_q, l_q, k_q;
  logic [IDX_W:0]   k_sum;
  logic [IDX_W-1:0] k_step;

  assign k_sum  = {1'b0, k_q} + {1'b0, l_q};
  assign k_step = (k_sum >= POINTS_W) ? IDX_W'(k_sum - POINTS_W) : k_sum[IDX_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_cnt_q <= '0;
      n_q        <= '0;
      l_q        <= '0;
      k_q        <= '0;
    end else begin
      if (cmd_i.load_en) begin
        load_cnt_q <= (load_cnt_q == LAST_IDX) ? '0 : load_cnt_q + 1'b1;
      end
      if (cmd_i.row_start) begin
        l_q <= '0;
      end else if (cmd_i.emit) begin
        l_q <= l_q + 1'b1;
      end
      if (cmd_i.bin_start) begin
        n_q <= '0;
        k_q <= '0;
      end else if (cmd_i.mac_issue) begin
        n_q <= n_q + 1'b1;
        k_q <= k_step;
      end
    end
  end

  // Row store: one write port for loading, one registered read port for the MAC
  logic [2*SAMPLE_W-1:0]      row_mem [POINTS];
  logic [2*SAMPLE_W-1:0]      rd_q;
  logic signed [SAMPLE_W-1:0] tw_c_q, tw_s_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_en) begin
      row_mem[load_cnt_q] <= {sample_re_i, sample_im_i};
    end
    if (cmd_i.mac_issue) begin
      rd_q   <= row_mem[n_q];
      tw_c_q <= rom_cos[k_q];
      tw_s_q <= rom_sin[k_q];
    end
  end

  // Pipeline step flags (valid and first-of-bin per stage)
  logic v1_q, v2_q, v3_q;
  logic f1_q, f2_q, f3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      f1_q <= 1'b0;
      f2_q <= 1'b0;
      f3_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.mac_issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
      f1_q <= cmd_i.mac_issue && (n_q == '0);
      f2_q <= f1_q;
      f3_q <= f2_q;
    end
  end

  // Stage 2: four 16x16 products
  logic signed [SAMPLE_W-1:0]   xr, xi;
  logic signed [2*SAMPLE_W-1:0] p_rc_q, p_is_q, p_ic_q, p_rs_q;

  assign xr = rd_q[2*SAMPLE_W-1:SAMPLE_W];
  assign xi = rd_q[SAMPLE_W-1:0];

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      p_rc_q <= xr * tw_c_q;
      p_is_q <= xi * tw_s_q;
      p_ic_q <= xi * tw_c_q;
      p_rs_q <= xr * tw_s_q;
    end
  end

  // Stage 3: combine products; forward negates the sine term
  logic signed [TERM_W-1:0] term_re_q, term_im_q;

  always_ff @(posedge clk_i) begin
    if (v2_q) begin
      if (dir_q) begin
        term_re_q <= TERM_W'(p_rc_q) - TERM_W'(p_is_q);
        term_im_q <= TERM_W'(p_ic_q) + TERM_W'(p_rs_q);
      end else begin
        term_re_q <= TERM_W'(p_rc_q) + TERM_W'(p_is_q);
        term_im_q <= TERM_W'(p_ic_q) - TERM_W'(p_rs_q);
      end
    end
  end

  // Stage 4: accumulate, wrapping at the bin width
  logic signed [BIN_W-1:0] acc_re_q, acc_im_q;

  always_ff @(posedge clk_i) begin
    if (v3_q) begin
      acc_re_q <= (f3_q ? '0 : acc_re_q) + BIN_W'(term_re_q);
      acc_im_q <= (f3_q ? '0 : acc_im_q) + BIN_W'(term_im_q);
    end
  end

  // Output register
  logic                    out_valid_q;
  logic signed [BIN_W-1:0] out_re_q, out_im_q;
  logic [BIN_IDX_W-1:0]    out_idx_q;
  logic                    out_last_q;
  logic                    out_free;

  assign out_free = !out_valid_q || bin_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (bin_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_re_q   <= acc_re_q;
      out_im_q   <= acc_im_q;
      out_idx_q  <= BIN_IDX_W'(l_q);
      out_last_q <= (l_q == LAST_IDX);
    end
  end

  assign bin_valid_o = out_valid_q;
  assign bin_re_o    = out_re_q;
  assign bin_im_o    = out_im_q;
  assign bin_index_o = out_idx_q;
  assign last_bin_o  = out_last_q;

  // Status to the controller
  always_comb begin
    stat_o           = '0;
    stat_o.load_last = (load_cnt_q == LAST_IDX);
    stat_o.n_last    = (n_q == LAST_IDX);
    stat_o.l_last    = (l_q == LAST_IDX);
    stat_o.pipe_busy = v1_q || v2_q || v3_q;
    stat_o.out_free  = out_free;
  end

endmodule

FILE: design/row_dft_engine.sv
// Direct complex DFT of one row of POINTS Q1.15 samples.
//
// Channels: sample_i takes one complex sample per item; the item that completes
// a row starts the transform. bin_o delivers POINTS bins in index order, each with
// 38-bit real and imaginary sums, the bin index modulo 64 and last_bin on the
// final bin. cfg_i writes the direction bit (0 forward, 1 inverse); it is always
// ready. The user must write it only while the block is idle; the block itself
// does not enforce this.
// While the block loads, sample_i is always ready. After the closing sample the
// single shared MAC runs POINTS steps per bin through a four-stage pipeline
// (store/ROM read, products, combine, accumulate); the pipeline then drains and
// the bin moves into the output register once that register is free.
// Samples of the next row are taken once the last bin sits in the output register.
// Reset clears the load position, the direction bit and the controller; the row
// store holds no reset value. If the receiver stalls, the finished bin waits in the
// output register; the MAC computes the next bin and then holds until it frees.
// Depends on rdft_pkg, the three channel interfaces, rdft_ctrl and rdft_datapath.
module row_dft_engine #(
  parameter int unsigned POINTS = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  rdft_sample_if.sink  sample_i,
  rdft_bin_if.source   bin_o,
  rdft_cfg_if.sink     cfg_i
);
  import rdft_pkg::*;

  rdft_cmd_t  cmd;
  rdft_stat_t stat;

  assign cfg_i.ready = 1'b1;

  // Sequencer
  rdft_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .sample_valid_i (sample_i.valid),
    .sample_ready_o (sample_i.ready),
    .stat_i         (stat),
    .cmd_o          (cmd)
  );

  // Storage, twiddles and MAC
  rdft_datapath #(
    .POINTS (POINTS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .sample_re_i     (sample_i.sample_re),
    .sample_im_i     (sample_i.sample_im),
    .cfg_we_i        (cfg_i.valid),
    .cfg_direction_i (cfg_i.direction),
    .bin_valid_o     (bin_o.valid),
    .bin_ready_i     (bin_o.ready),
    .bin_re_o        (bin_o.bin_re),
    .bin_im_o        (bin_o.bin_im),
    .bin_index_o     (bin_o.bin_index),
    .last_bin_o      (bin_o.last_bin)
  );

endmodule
